@@ rtl/core/epoch_seconds_to_calendar_macros.svh @@
// -----------------------------------------------------------------------------
// Epoch seconds to calendar: assertion macros
// Shared concurrent check forms, clocked on clk and disabled in reset.
// -----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH

// antecedent a implies consequent c in the same cycle
`define ES2C_ASSERT_IMPLY(label, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// condition bad never holds
`define ES2C_ASSERT_NEVER(label, bad, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) \
        else $error(msg);

`endif

@@ rtl/core/es2c_pkg.sv @@
// -----------------------------------------------------------------------------
// es2c_pkg
// Widths, calendar constants, reciprocal multipliers and the month table.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package es2c_pkg;

    // field and intermediate widths
    localparam int unsigned SECS_W  = 31;
    localparam int unsigned MINS_W  = 26;
    localparam int unsigned HOURS_W = 20;
    localparam int unsigned DAYS_W  = 15;
    localparam int unsigned Q4_W    = 5;
    localparam int unsigned YOE_W   = 7;
    localparam int unsigned DOY_W   = 9;
    localparam int unsigned MP_W    = 4;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned DOM_W   = 5;
    localparam int unsigned MON_W   = 4;
    localparam int unsigned YEAR_W  = 12;

    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned MINS_PER_HOUR = 60;
    localparam int unsigned HOURS_PER_DAY = 24;

    // day number of 2020-01-01 counted from 0000-03-01
    localparam int unsigned EPOCH_DAY_OFFSET = 737730;
    localparam int unsigned DAYS_PER_ERA     = 146097;
    localparam int unsigned DAYS_PER_4Y      = 1460;
    localparam int unsigned DAYS_PER_YEAR    = 365;
    localparam int unsigned MONTH_SPAN_NUM   = 153;
    localparam int unsigned MP_SCALE         = 5;
    localparam int unsigned MP_BIAS          = 2;

    // 31-bit counts reach only 2088, so every day falls in one era
    localparam int unsigned ERA_BASE   = EPOCH_DAY_OFFSET / DAYS_PER_ERA;
    localparam int unsigned DOE_OFFSET = EPOCH_DAY_OFFSET - ERA_BASE * DAYS_PER_ERA;
    localparam int unsigned YEAR_BASE  = ERA_BASE * 400;

    // March-based month index of January, and civil month of index zero
    localparam int unsigned MP_JAN      = 10;
    localparam int unsigned MON_OF_MP0  = 3;

    // rounded-up reciprocals; shifts chosen so the quotient is exact over the range
    localparam int unsigned SEC_SHIFT   = 37;
    localparam int unsigned SEC_RECIP_W = 32;
    localparam logic [SEC_RECIP_W-1:0] SEC_RECIP =
        SEC_RECIP_W'(((64'd1 << SEC_SHIFT) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN));

    localparam int unsigned MIN_SHIFT   = 32;
    localparam int unsigned MIN_RECIP_W = 27;
    localparam logic [MIN_RECIP_W-1:0] MIN_RECIP =
        MIN_RECIP_W'(((64'd1 << MIN_SHIFT) + 64'(MINS_PER_HOUR) - 64'd1)
                     / 64'(MINS_PER_HOUR));

    localparam int unsigned HOUR_SHIFT   = 24;
    localparam int unsigned HOUR_RECIP_W = 20;
    localparam logic [HOUR_RECIP_W-1:0] HOUR_RECIP =
        HOUR_RECIP_W'(((64'd1 << HOUR_SHIFT) + 64'(HOURS_PER_DAY) - 64'd1)
                      / 64'(HOURS_PER_DAY));

    localparam int unsigned Q4_SHIFT   = 25;
    localparam int unsigned Q4_RECIP_W = 15;
    localparam logic [Q4_RECIP_W-1:0] Q4_RECIP =
        Q4_RECIP_W'(((64'd1 << Q4_SHIFT) + 64'(DAYS_PER_4Y) - 64'd1) / 64'(DAYS_PER_4Y));

    localparam int unsigned YEAR_SHIFT   = 24;
    localparam int unsigned YEAR_RECIP_W = 16;
    localparam logic [YEAR_RECIP_W-1:0] YEAR_RECIP =
        YEAR_RECIP_W'(((64'd1 << YEAR_SHIFT) + 64'(DAYS_PER_YEAR) - 64'd1)
                      / 64'(DAYS_PER_YEAR));

    localparam int unsigned MP_SHIFT   = 20;
    localparam int unsigned MP_RECIP_W = 13;
    localparam int unsigned MP_NUM_W   = 11;
    localparam logic [MP_RECIP_W-1:0] MP_RECIP =
        MP_RECIP_W'(((64'd1 << MP_SHIFT) + 64'(MONTH_SPAN_NUM) - 64'd1)
                    / 64'(MONTH_SPAN_NUM));

    typedef struct packed {
        logic [SEC_W-1:0]  second;
        logic [MIN_W-1:0]  minute;
        logic [HOUR_W-1:0] hour;
    } es2c_clock_t;

    // first day of year (March-based) of each month index
    function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
        logic [DOY_W-1:0] start;
        case (mp)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd61;
            4'd3:    start = 9'd92;
            4'd4:    start = 9'd122;
            4'd5:    start = 9'd153;
            4'd6:    start = 9'd184;
            4'd7:    start = 9'd214;
            4'd8:    start = 9'd245;
            4'd9:    start = 9'd275;
            4'd10:   start = 9'd306;
            4'd11:   start = 9'd337;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/es2c_tod.sv @@
// -----------------------------------------------------------------------------
// es2c_tod
// Four-stage split of the seconds count into second, minute, hour and a
// day-of-era number.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module es2c_tod (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [es2c_pkg::SECS_W-1:0]      seconds_since_epoch,
    output logic                                  dn_valid,
    input  wire logic                             dn_stall,
    output es2c_pkg::es2c_clock_t                 dn_clock,
    output logic [es2c_pkg::DAYS_W-1:0]           dn_doe
);

    localparam int unsigned P1_W = es2c_pkg::SECS_W + es2c_pkg::SEC_RECIP_W;
    localparam int unsigned P2_W = es2c_pkg::MINS_W + es2c_pkg::MIN_RECIP_W;
    localparam int unsigned P3_W = es2c_pkg::HOURS_W + es2c_pkg::HOUR_RECIP_W;

    logic [3:0] valid_reg;
    logic [3:0] advance;

    logic [es2c_pkg::SECS_W-1:0]  secs1_reg;
    logic [es2c_pkg::MINS_W-1:0]  mins1_reg, mins1_next;
    logic [es2c_pkg::MINS_W-1:0]  mins2_reg;
    logic [es2c_pkg::HOURS_W-1:0] hours2_reg, hours2_next;
    logic [es2c_pkg::SEC_W-1:0]   sec2_reg, sec2_next;
    logic [es2c_pkg::HOURS_W-1:0] hours3_reg;
    logic [es2c_pkg::DAYS_W-1:0]  days3_reg, days3_next;
    logic [es2c_pkg::SEC_W-1:0]   sec3_reg;
    logic [es2c_pkg::MIN_W-1:0]   min3_reg, min3_next;
    es2c_pkg::es2c_clock_t        clock4_reg, clock4_next;
    logic [es2c_pkg::DAYS_W-1:0]  doe4_reg, doe4_next;

    logic [P1_W-1:0]              prod1;
    logic [P2_W-1:0]              prod2;
    logic [P3_W-1:0]              prod3;
    logic [es2c_pkg::SECS_W-1:0]  rem2;
    logic [es2c_pkg::MINS_W-1:0]  rem3;
    logic [es2c_pkg::HOURS_W-1:0] rem4;

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        advance[3] = !valid_reg[3] || !dn_stall;
        advance[2] = !valid_reg[2] || advance[3];
        advance[1] = !valid_reg[1] || advance[2];
        advance[0] = !valid_reg[0] || advance[1];
    end

    always_comb
    begin
        prod1      = P1_W'(seconds_since_epoch) * P1_W'(es2c_pkg::SEC_RECIP);
        mins1_next = prod1[es2c_pkg::SEC_SHIFT +: es2c_pkg::MINS_W];

        prod2       = P2_W'(mins1_reg) * P2_W'(es2c_pkg::MIN_RECIP);
        hours2_next = prod2[es2c_pkg::MIN_SHIFT +: es2c_pkg::HOURS_W];
        rem2        = secs1_reg - (es2c_pkg::SECS_W'(mins1_reg)
                                   * es2c_pkg::SECS_W'(es2c_pkg::SECS_PER_MIN));
        sec2_next   = rem2[es2c_pkg::SEC_W-1:0];

        prod3      = P3_W'(hours2_reg) * P3_W'(es2c_pkg::HOUR_RECIP);
        days3_next = prod3[es2c_pkg::HOUR_SHIFT +: es2c_pkg::DAYS_W];
        rem3       = mins2_reg - (es2c_pkg::MINS_W'(hours2_reg)
                                  * es2c_pkg::MINS_W'(es2c_pkg::MINS_PER_HOUR));
        min3_next  = rem3[es2c_pkg::MIN_W-1:0];

        rem4               = hours3_reg - (es2c_pkg::HOURS_W'(days3_reg)
                                           * es2c_pkg::HOURS_W'(es2c_pkg::HOURS_PER_DAY));
        clock4_next.second = sec3_reg;
        clock4_next.minute = min3_reg;
        clock4_next.hour   = rem4[es2c_pkg::HOUR_W-1:0];
        doe4_next          = days3_reg + es2c_pkg::DAYS_W'(es2c_pkg::DOE_OFFSET);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (advance[0])
                valid_reg[0] <= in_valid;
            if (advance[1])
                valid_reg[1] <= valid_reg[0];
            if (advance[2])
                valid_reg[2] <= valid_reg[1];
            if (advance[3])
                valid_reg[3] <= valid_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance[0])
        begin
            secs1_reg <= seconds_since_epoch;
            mins1_reg <= mins1_next;
        end
        if (advance[1])
        begin
            mins2_reg  <= mins1_reg;
            hours2_reg <= hours2_next;
            sec2_reg   <= sec2_next;
        end
        if (advance[2])
        begin
            hours3_reg <= hours2_reg;
            days3_reg  <= days3_next;
            sec3_reg   <= sec2_reg;
            min3_reg   <= min3_next;
        end
        if (advance[3])
        begin
            clock4_reg <= clock4_next;
            doe4_reg   <= doe4_next;
        end
    end

    assign in_stall = !advance[0];
    assign dn_valid = valid_reg[3];
    assign dn_clock = clock4_reg;
    assign dn_doe   = doe4_reg;

endmodule

`default_nettype wire

@@ rtl/core/es2c_date.sv @@
// -----------------------------------------------------------------------------
// es2c_date
// Four-stage day-of-era to year-of-era, day-of-year and March-based month.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module es2c_date (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            up_valid,
    output logic                                 up_stall,
    input  wire es2c_pkg::es2c_clock_t           up_clock,
    input  wire logic [es2c_pkg::DAYS_W-1:0]     up_doe,
    output logic                                 dn_valid,
    input  wire logic                            dn_stall,
    output es2c_pkg::es2c_clock_t                dn_clock,
    output logic [es2c_pkg::YOE_W-1:0]           dn_yoe,
    output logic [es2c_pkg::DOY_W-1:0]           dn_doy,
    output logic [es2c_pkg::MP_W-1:0]            dn_mp
);

    localparam int unsigned PQ_W = es2c_pkg::DAYS_W + es2c_pkg::Q4_RECIP_W;
    localparam int unsigned PY_W = es2c_pkg::DAYS_W + es2c_pkg::YEAR_RECIP_W;
    localparam int unsigned PM_W = es2c_pkg::MP_NUM_W + es2c_pkg::MP_RECIP_W;

    logic [3:0] valid_reg;
    logic [3:0] advance;

    es2c_pkg::es2c_clock_t         clock1_reg, clock2_reg, clock3_reg, clock4_reg;
    logic [es2c_pkg::DAYS_W-1:0]   doe1_reg, doe2_reg;
    logic [es2c_pkg::Q4_W-1:0]     q4_1_reg, q4_1_next;
    logic [es2c_pkg::YOE_W-1:0]    yoe2_reg, yoe2_next, yoe3_reg, yoe4_reg;
    logic [es2c_pkg::DOY_W-1:0]    doy3_reg, doy3_next, doy4_reg;
    logic [es2c_pkg::MP_W-1:0]     mp4_reg, mp4_next;

    logic [PQ_W-1:0]               prod_q4;
    logic [es2c_pkg::DAYS_W-1:0]   yoe_num;
    logic [PY_W-1:0]               prod_yoe;
    logic [es2c_pkg::DAYS_W-1:0]   year_span;
    logic [es2c_pkg::DAYS_W-1:0]   doy_full;
    logic [es2c_pkg::MP_NUM_W-1:0] mp_num;
    logic [PM_W-1:0]               prod_mp;

    always_comb
    begin
        advance[3] = !valid_reg[3] || !dn_stall;
        advance[2] = !valid_reg[2] || advance[3];
        advance[1] = !valid_reg[1] || advance[2];
        advance[0] = !valid_reg[0] || advance[1];
    end

    // the century terms of the year formula are zero below 36524 days of era
    always_comb
    begin
        prod_q4   = PQ_W'(up_doe) * PQ_W'(es2c_pkg::Q4_RECIP);
        q4_1_next = prod_q4[es2c_pkg::Q4_SHIFT +: es2c_pkg::Q4_W];

        yoe_num   = doe1_reg - es2c_pkg::DAYS_W'(q4_1_reg);
        prod_yoe  = PY_W'(yoe_num) * PY_W'(es2c_pkg::YEAR_RECIP);
        yoe2_next = prod_yoe[es2c_pkg::YEAR_SHIFT +: es2c_pkg::YOE_W];

        year_span = es2c_pkg::DAYS_W'(yoe2_reg) * es2c_pkg::DAYS_W'(es2c_pkg::DAYS_PER_YEAR)
                    + es2c_pkg::DAYS_W'(yoe2_reg >> 2);
        doy_full  = doe2_reg - year_span;
        doy3_next = doy_full[es2c_pkg::DOY_W-1:0];

        mp_num   = es2c_pkg::MP_NUM_W'(doy3_reg) * es2c_pkg::MP_NUM_W'(es2c_pkg::MP_SCALE)
                   + es2c_pkg::MP_NUM_W'(es2c_pkg::MP_BIAS);
        prod_mp  = PM_W'(mp_num) * PM_W'(es2c_pkg::MP_RECIP);
        mp4_next = prod_mp[es2c_pkg::MP_SHIFT +: es2c_pkg::MP_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (advance[0])
                valid_reg[0] <= up_valid;
            if (advance[1])
                valid_reg[1] <= valid_reg[0];
            if (advance[2])
                valid_reg[2] <= valid_reg[1];
            if (advance[3])
                valid_reg[3] <= valid_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance[0])
        begin
            clock1_reg <= up_clock;
            doe1_reg   <= up_doe;
            q4_1_reg   <= q4_1_next;
        end
        if (advance[1])
        begin
            clock2_reg <= clock1_reg;
            doe2_reg   <= doe1_reg;
            yoe2_reg   <= yoe2_next;
        end
        if (advance[2])
        begin
            clock3_reg <= clock2_reg;
            yoe3_reg   <= yoe2_reg;
            doy3_reg   <= doy3_next;
        end
        if (advance[3])
        begin
            clock4_reg <= clock3_reg;
            yoe4_reg   <= yoe3_reg;
            doy4_reg   <= doy3_reg;
            mp4_reg    <= mp4_next;
        end
    end

    assign up_stall = !advance[0];
    assign dn_valid = valid_reg[3];
    assign dn_clock = clock4_reg;
    assign dn_yoe   = yoe4_reg;
    assign dn_doy   = doy4_reg;
    assign dn_mp    = mp4_reg;

endmodule

`default_nettype wire

@@ rtl/core/epoch_seconds_to_calendar.sv @@
// -----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Seconds since 2020-01-01 00:00:00 to second, minute, hour, day, month, year.
// -----------------------------------------------------------------------------
// Channel  Handshake            Payload
// in       in_valid, in_stall   seconds_since_epoch[30:0]
// out      out_valid, out_stall second, minute, hour, day, month, year
//
// One beat per cycle while out_stall is low; four time-of-day stages, four date
// stages and the output register.
// Reset clears the valid bits only; the data registers are not reset.
// out_stall holds only the stages that are full: bubbles close up, and
// in_stall rises only when all nine stages hold a beat.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "epoch_seconds_to_calendar_macros.svh"

module epoch_seconds_to_calendar (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [es2c_pkg::SECS_W-1:0]   seconds_since_epoch,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [es2c_pkg::SEC_W-1:0]         second,
    output logic [es2c_pkg::MIN_W-1:0]         minute,
    output logic [es2c_pkg::HOUR_W-1:0]        hour,
    output logic [es2c_pkg::DOM_W-1:0]         day,
    output logic [es2c_pkg::MON_W-1:0]         month,
    output logic [es2c_pkg::YEAR_W-1:0]        year
);

    logic                           tod_valid;
    logic                           tod_stall;
    es2c_pkg::es2c_clock_t          tod_clock;
    logic [es2c_pkg::DAYS_W-1:0]    tod_doe;

    logic                           date_valid;
    logic                           date_stall;
    es2c_pkg::es2c_clock_t          date_clock;
    logic [es2c_pkg::YOE_W-1:0]     date_yoe;
    logic [es2c_pkg::DOY_W-1:0]     date_doy;
    logic [es2c_pkg::MP_W-1:0]      date_mp;

    logic                           out_valid_reg;
    logic                           out_advance;
    es2c_pkg::es2c_clock_t          clock_reg;
    logic [es2c_pkg::DOM_W-1:0]     dom_reg, dom_next;
    logic [es2c_pkg::MON_W-1:0]     mon_reg, mon_next;
    logic [es2c_pkg::YEAR_W-1:0]    year_reg, year_next;

    logic [es2c_pkg::DOY_W-1:0]     dom_full;
    logic                           jan_feb;

    es2c_tod u_tod (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .seconds_since_epoch (seconds_since_epoch),
        .dn_valid            (tod_valid),
        .dn_stall            (tod_stall),
        .dn_clock            (tod_clock),
        .dn_doe              (tod_doe)
    );

    es2c_date u_date (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (tod_valid),
        .up_stall (tod_stall),
        .up_clock (tod_clock),
        .up_doe   (tod_doe),
        .dn_valid (date_valid),
        .dn_stall (date_stall),
        .dn_clock (date_clock),
        .dn_yoe   (date_yoe),
        .dn_doy   (date_doy),
        .dn_mp    (date_mp)
    );

    // January and February close the March-based year, so they count to the next one
    always_comb
    begin
        out_advance = !out_valid_reg || !out_stall;
        jan_feb     = (date_mp >= es2c_pkg::MP_W'(es2c_pkg::MP_JAN));
        dom_full    = date_doy - es2c_pkg::month_start(date_mp) + es2c_pkg::DOY_W'(1);
        dom_next    = dom_full[es2c_pkg::DOM_W-1:0];
        if (jan_feb)
            mon_next = es2c_pkg::MON_W'(date_mp - es2c_pkg::MP_W'(es2c_pkg::MP_JAN) + 4'd1);
        else
            mon_next = es2c_pkg::MON_W'(date_mp + es2c_pkg::MP_W'(es2c_pkg::MON_OF_MP0));
        year_next   = es2c_pkg::YEAR_W'(es2c_pkg::YEAR_BASE) + es2c_pkg::YEAR_W'(date_yoe)
                      + es2c_pkg::YEAR_W'(jan_feb);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= date_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_advance)
        begin
            clock_reg <= date_clock;
            dom_reg   <= dom_next;
            mon_reg   <= mon_next;
            year_reg  <= year_next;
        end
    end

    assign date_stall = !out_advance;
    assign out_valid  = out_valid_reg;
    assign second     = clock_reg.second;
    assign minute     = clock_reg.minute;
    assign hour       = clock_reg.hour;
    assign day        = dom_reg;
    assign month      = mon_reg;
    assign year       = year_reg;

    `ES2C_ASSERT_IMPLY(a_stall_only_full, in_stall, out_valid && out_stall, "stall with room")
    `ES2C_ASSERT_IMPLY(a_month_range, out_valid, month >= 4'd1 && month <= 4'd12, "bad month")
    `ES2C_ASSERT_IMPLY(a_day_range, out_valid, day != 5'd0, "bad day of month")
    `ES2C_ASSERT_IMPLY(a_hour_range, out_valid, hour <= 5'd23, "bad hour")
    `ES2C_ASSERT_IMPLY(a_min_sec_range, out_valid, minute <= 6'd59 && second <= 6'd59, "bad time")
    `ES2C_ASSERT_NEVER(a_feb_length, out_valid && month == 4'd2 && day > 5'd29, "February past 29")

endmodule

`default_nettype wire
